FILE: rtl/rse_pkg.sv
// Types and constants shared by the RTT smoothing estimator.
// No dependencies; imported by rse_filter, rse_epoch and rtt_smoothing_estimator.
package rse_pkg;

    // Reset value of the throttle interval, in ms
    localparam logic [15:0] THROTTLE_RESET = 16'd5000;
    // Wrapped time differences at or above this are read backwards
    localparam logic [31:0] TIME_OVERFLOW  = 32'd86400000;

    // One input item
    typedef struct packed {
        logic [31:0] sample_time;
        logic [15:0] rtt_sample;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic [15:0] smoothed_rtt;
        logic [15:0] rtt_variance;
        logic [15:0] epoch_low_rtt;
        logic [15:0] epoch_high_variance;
        logic        epoch_closed;
    } t_out_item;

    // Estimator state after one sample
    typedef struct packed {
        logic [15:0] rtt_avg;
        logic [15:0] rtt_var;
    } t_est;

    // Epoch decision and next tracker values
    typedef struct packed {
        logic        closed;
        logic [15:0] latched_low;
        logic [15:0] latched_high_var;
        logic [15:0] lowest_seen;
        logic [15:0] highest_var_seen;
    } t_epoch_upd;

endpackage

FILE: rtl/rse_filter.sv
// Smoothed RTT and variance update for one sample.
// Depends on rse_pkg.
module rse_filter (
    input  logic [15:0]   i_sample,
    input  rse_pkg::t_est i_est,
    output rse_pkg::t_est o_est
);
    import rse_pkg::*;

    logic [15:0] var_dec;
    logic        up;
    logic [15:0] diff;

    // Variance loses a quarter first
    assign var_dec = i_est.rtt_var - {2'b00, i_est.rtt_var[15:2]};

    // Absolute difference from the old average
    assign up   = (i_sample >= i_est.rtt_avg);
    assign diff = up ? (i_sample - i_est.rtt_avg) : (i_est.rtt_avg - i_sample);

    // Move an eighth of the way; variance gains a quarter of the difference
    always_comb begin
        o_est.rtt_avg = up ? (i_est.rtt_avg + {3'b000, diff[15:3]})
                           : (i_est.rtt_avg - {3'b000, diff[15:3]});
        o_est.rtt_var = var_dec + {2'b00, diff[15:2]};
    end

endmodule

FILE: rtl/rse_epoch.sv
// Epoch tracking: min RTT / max variance trackers and the epoch close test.
// Depends on rse_pkg.
module rse_epoch (
    input  logic [31:0]         i_now,
    input  logic [31:0]         i_epoch_start,
    input  logic [15:0]         i_interval,
    input  rse_pkg::t_est       i_est,
    input  logic [15:0]         i_lowest,
    input  logic [15:0]         i_highest,
    input  logic [15:0]         i_latched_low,
    input  logic [15:0]         i_latched_high,
    output rse_pkg::t_epoch_upd o_upd
);
    import rse_pkg::*;

    logic [15:0] low_trk;
    logic [15:0] high_trk;
    logic [31:0] fwd;
    logic [31:0] tdiff;
    logic        close;

    // Trackers take in the new values
    assign low_trk  = (i_est.rtt_avg < i_lowest)  ? i_est.rtt_avg : i_lowest;
    assign high_trk = (i_est.rtt_var > i_highest) ? i_est.rtt_var : i_highest;

    // Wrapped time difference; large forward gaps mean the time lies before the epoch
    assign fwd   = i_now - i_epoch_start;
    assign tdiff = (fwd >= TIME_OVERFLOW) ? (i_epoch_start - i_now) : fwd;
    assign close = (i_epoch_start == 32'd0) || (tdiff >= {16'd0, i_interval});

    // Latch and restart on close
    always_comb begin
        o_upd.closed = close;
        if (close) begin
            o_upd.latched_low      = low_trk;
            o_upd.latched_high_var = high_trk;
            o_upd.lowest_seen      = i_est.rtt_avg;
            o_upd.highest_var_seen = i_est.rtt_var;
        end else begin
            o_upd.latched_low      = i_latched_low;
            o_upd.latched_high_var = i_latched_high;
            o_upd.lowest_seen      = low_trk;
            o_upd.highest_var_seen = high_trk;
        end
    end

endmodule

FILE: rtl/rtt_smoothing_estimator.sv
// RTT smoothing estimator: smoothed RTT, variance and per-epoch min/max.
// An accepted item waits in the input register; the result register loads from it
// when it is free or being emptied, so a stalled receiver holds the item there.
// Throughput: one item per cycle unless the receiver stalls, set by the update loop.
// Reset (synchronous, active low) restores the default RTT, zero variance,
// an unset epoch and a throttle interval of 5000 ms. Depends on rse_pkg.
module rtt_smoothing_estimator #(
    parameter int DEFAULT_RTT = 500
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rse_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rse_pkg::t_out_item  o_out_item
);
    import rse_pkg::*;

    localparam logic [15:0] RTT_RESET = DEFAULT_RTT[15:0];

    logic [15:0] r_interval;
    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    t_est        r_est;
    logic [15:0] r_lowest;
    logic [15:0] r_highest;
    logic [15:0] r_latched_low;
    logic [15:0] r_latched_high;
    logic [31:0] r_epoch_start;

    t_est        n_est;
    t_epoch_upd  n_upd;
    logic        advance;

    // Stage moves on when the result register is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    rse_filter u_filter (
        .i_sample (r_in.rtt_sample),
        .i_est    (r_est),
        .o_est    (n_est)
    );

    rse_epoch u_epoch (
        .i_now          (r_in.sample_time),
        .i_epoch_start  (r_epoch_start),
        .i_interval     (r_interval),
        .i_est          (n_est),
        .i_lowest       (r_lowest),
        .i_highest      (r_highest),
        .i_latched_low  (r_latched_low),
        .i_latched_high (r_latched_high),
        .o_upd          (n_upd)
    );

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= THROTTLE_RESET;
        end else if (i_cfg_we) begin
            r_interval <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // Estimator and epoch state, updated as an item passes to the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est.rtt_avg  <= RTT_RESET;
            r_est.rtt_var  <= 16'd0;
            r_lowest       <= RTT_RESET;
            r_highest      <= 16'd0;
            r_latched_low  <= RTT_RESET;
            r_latched_high <= 16'd0;
            r_epoch_start  <= 32'd0;
        end else if (advance) begin
            r_est          <= n_est;
            r_lowest       <= n_upd.lowest_seen;
            r_highest      <= n_upd.highest_var_seen;
            r_latched_low  <= n_upd.latched_low;
            r_latched_high <= n_upd.latched_high_var;
            if (n_upd.closed) begin
                r_epoch_start <= r_in.sample_time;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.smoothed_rtt        <= n_est.rtt_avg;
            r_out.rtt_variance        <= n_est.rtt_var;
            r_out.epoch_low_rtt       <= n_upd.latched_low;
            r_out.epoch_high_variance <= n_upd.latched_high_var;
            r_out.epoch_closed        <= n_upd.closed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef ASSERT_OFF
    // Lowest tracker never exceeds the current average
    a_low_le_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lowest <= r_est.rtt_avg)
        else $error("lowest RTT tracker above smoothed RTT");

    // Highest tracker never falls below the current variance
    a_high_ge_var: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_highest >= r_est.rtt_var)
        else $error("highest variance tracker below variance");

    // A closing item stores its time as the epoch start
    a_epoch_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_upd.closed) |=> (r_epoch_start == $past(r_in.sample_time)))
        else $error("epoch start not taken from closing item");

    // Latched values hold while an epoch stays open
    a_latch_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !n_upd.closed) |=> ($stable(r_latched_low) && $stable(r_latched_high)))
        else $error("latched values changed without epoch close");
`endif

endmodule

FILE: sim/rse_checker.sv
`timescale 1ns / 100ps
// Result checker for the RTT smoothing estimator: watches both channels and the
// interval write port, predicts each result and compares it. Depends on rse_pkg.
module rse_checker #(
    parameter int DEFAULT_RTT = 500
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  rse_pkg::t_in_item   i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  rse_pkg::t_out_item  i_out_item,
    output int                  o_pending,
    output int                  o_fail_count
);
    import rse_pkg::*;

    // At most two items are held inside the block at once
    localparam int EXP_DEPTH = 4;

    // Shadow copy of the estimator state and the interval
    logic [15:0] interval_q;
    logic [15:0] avg_q;
    logic [15:0] var_q;
    logic [15:0] low_seen_q;
    logic [15:0] high_seen_q;
    logic [15:0] low_latch_q;
    logic [15:0] high_latch_q;
    logic [31:0] epoch_q;

    // Expected results in order, as a small ring
    t_out_item   expected_mem [EXP_DEPTH];
    logic [1:0]  exp_wr_ptr;
    logic [1:0]  exp_rd_ptr;
    int          exp_count = 0;
    int          fails = 0;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    // Wrapped distance in time; a huge forward gap means the time lies behind
    function automatic logic [31:0] wrapped_gap(logic [31:0] now, logic [31:0] start);
        logic [31:0] d;
        d = now - start;
        return (d >= TIME_OVERFLOW) ? (start - now) : d;
    endfunction

    // Fold one sample into the shadow state and give the result it causes
    task automatic advance_estimate(input t_in_item it, output t_out_item res);
        logic [15:0] old_avg;
        logic [15:0] diff;
        logic [15:0] decayed;
        logic        closed;
        old_avg = avg_q;
        decayed = var_q - (var_q >> 2);
        if (it.rtt_sample >= old_avg) begin
            diff  = it.rtt_sample - old_avg;
            avg_q = old_avg + (diff >> 3);
        end else begin
            diff  = old_avg - it.rtt_sample;
            avg_q = old_avg - (diff >> 3);
        end
        // cannot exceed 16 bits: 49152 + 16383 at most
        var_q = decayed + (diff >> 2);

        if (avg_q < low_seen_q)
            low_seen_q = avg_q;
        if (var_q > high_seen_q)
            high_seen_q = var_q;

        closed = (epoch_q == 32'd0) ||
                 (wrapped_gap(it.sample_time, epoch_q) >= {16'd0, interval_q});
        if (closed) begin
            low_latch_q  = low_seen_q;
            high_latch_q = high_seen_q;
            low_seen_q   = avg_q;
            high_seen_q  = var_q;
            epoch_q      = it.sample_time;
        end

        res.smoothed_rtt        = avg_q;
        res.rtt_variance        = var_q;
        res.epoch_low_rtt       = low_latch_q;
        res.epoch_high_variance = high_latch_q;
        res.epoch_closed        = closed;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // Channel monitor: results first, since no item can leave on the edge it enters
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            interval_q   = THROTTLE_RESET;
            avg_q        = DEFAULT_RTT[15:0];
            var_q        = '0;
            low_seen_q   = DEFAULT_RTT[15:0];
            high_seen_q  = '0;
            low_latch_q  = DEFAULT_RTT[15:0];
            high_latch_q = '0;
            epoch_q      = '0;
            exp_wr_ptr   = '0;
            exp_rd_ptr   = '0;
            exp_count    = 0;
        end else begin
            if (i_cfg_we)
                interval_q = i_cfg_wdata;

            if (i_out_valid && i_out_ready) begin
                got = i_out_item;
                if (exp_count == 0) begin
                    $error("result item with nothing expected: %h", got);
                    fails++;
                end else begin
                    want       = expected_mem[exp_rd_ptr];
                    exp_rd_ptr = exp_rd_ptr + 2'd1;
                    exp_count--;
                    check_field("smoothed_rtt", 32'(want.smoothed_rtt),
                                32'(got.smoothed_rtt));
                    check_field("rtt_variance", 32'(want.rtt_variance),
                                32'(got.rtt_variance));
                    check_field("epoch_low_rtt", 32'(want.epoch_low_rtt),
                                32'(got.epoch_low_rtt));
                    check_field("epoch_high_variance", 32'(want.epoch_high_variance),
                                32'(got.epoch_high_variance));
                    check_field("epoch_closed", 32'(want.epoch_closed),
                                32'(got.epoch_closed));
                end
            end

            if (i_in_valid && i_in_ready) begin
                advance_estimate(i_in_item, want);
                if (exp_count == EXP_DEPTH) begin
                    $error("more items in flight than the block can hold");
                    fails++;
                end else begin
                    expected_mem[exp_wr_ptr] = want;
                    exp_wr_ptr = exp_wr_ptr + 2'd1;
                    exp_count++;
                end
            end
        end
        o_pending    <= exp_count;
        o_fail_count <= fails;
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Top of the RTT smoothing estimator testbench: clock, reset, stimulus and verdict.
// Depends on rse_pkg, rtt_smoothing_estimator and rse_checker.
module tb;
    import rse_pkg::*;

    localparam int DEFAULT_RTT = 500;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_item;
    int          pending;
    int          fail_count;

    // Sender pacing and stimulus state
    int          burst_left    = 0;
    bit          gapless       = 1'b0;
    bit          long_hold_req = 1'b0;
    logic [31:0] cur_time      = '0;
    logic [15:0] rtt_base      = 16'd500;

    rtt_smoothing_estimator #(
        .DEFAULT_RTT (DEFAULT_RTT)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    rse_checker #(
        .DEFAULT_RTT (DEFAULT_RTT)
    ) checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop
    initial begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: random stall modes, plus one long hold-off on request
    initial begin
        int mode;
        int span;
        forever begin
            if (long_hold_req) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold_req = 1'b0;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            repeat (span) begin
                if (long_hold_req)
                    break;
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 4) == 0);
                    default: out_ready <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Offer one item; gaps fall between bursts unless the phase runs gapless
    task automatic send_sample(input logic [31:0] t, input logic [15:0] s);
        if (burst_left == 0) begin
            if (!gapless) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_item  <= '{sample_time: t, rtt_sample: s};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
    endtask

    // Stop offering and wait until every result is out
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_interval(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly forward time steps around the interval, with jumps back and wraps
    task automatic step_time(input logic [15:0] intv);
        case ($urandom_range(0, 11))
            0: cur_time = $urandom;
            1: cur_time = 32'd0;
            2: cur_time = cur_time - $urandom_range(0, intv + 2);
            3: cur_time = cur_time + TIME_OVERFLOW - $urandom_range(0, 2);
            4: cur_time = cur_time + intv;
            default: cur_time = cur_time + $urandom_range(0, 2 * intv + 2);
        endcase
    endtask

    // Samples wander around a base that moves now and then
    function automatic logic [15:0] next_rtt();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            3: begin
                rtt_base = 16'($urandom_range(1, 2000));
                return rtt_base;
            end
            default: return 16'(rtt_base + $urandom_range(0, 64) - 32);
        endcase
    endfunction

    // Stimulus and verdict
    initial begin
        logic [15:0] intv;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default interval: unset epoch, epoch at time zero, exact interval,
        // time behind the epoch, wrap of the counter, the backwards limit
        send_sample(32'd0, 16'd0);
        send_sample(32'd0, 16'hFFFF);
        send_sample(32'd100, 16'hFFFF);
        send_sample(32'd200, 16'd500);
        send_sample(32'd5100, 16'd0);
        send_sample(32'd5099, 16'hFFFF);
        send_sample(32'hFFFF_FC7C, 16'd0);
        send_sample(32'hFFFF_FFFF, 16'hFFFF);
        send_sample(32'd4100, 16'd0);
        send_sample(32'd86404100, 16'hFFFF);
        send_sample(32'd172804099, 16'd0);
        send_sample(32'd172809098, 16'hFFFF);
        send_sample(32'd172809099, 16'd0);
        for (int k = 0; k < 6; k++)
            send_sample(32'd172809100 + k, (k % 2) ? 16'd0 : 16'hFFFF);

        // Zero interval closes every epoch
        settle();
        write_interval(16'd0);
        send_sample(32'd1, 16'd7);
        send_sample(32'd1, 16'd9);
        send_sample(32'd2, 16'hFFFF);

        // Widest interval
        settle();
        write_interval(16'hFFFF);
        send_sample(32'd10, 16'd300);
        send_sample(32'd65544, 16'd200);
        send_sample(32'd65545, 16'd100);

        // Random phases over several intervals
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: intv = 16'd0;
                1: intv = 16'hFFFF;
                2: intv = 16'($urandom_range(1, 300));
                3: intv = 16'd1;
                4: intv = 16'($urandom_range(0, 65535));
                default: intv = 16'($urandom_range(100, 8000));
            endcase
            settle();
            write_interval(intv);
            gapless = (p == 2) || (p == 4);
            if ($urandom_range(0, 1))
                cur_time = $urandom;
            for (int n = 0; n < 100; n++) begin
                // back-pressure while the sender keeps offering
                if (p == 2 && n == 5)
                    long_hold_req = 1'b1;
                // sender pause until all results are out
                if (p == 1 && n == 50)
                    settle();
                step_time(intv);
                send_sample(cur_time, next_rtt());
            end
        end

        settle();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
